// ----- sv/video_frame_crc_framer_top_assert.svh -----
// Assertion macros for the video frame CRC framer checker.
`ifndef VIDEO_FRAME_CRC_FRAMER_TOP_ASSERT_SVH
`define VIDEO_FRAME_CRC_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VFCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VFCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define VFCF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/vfcf_pkg.sv -----
// Package: types, constants and CRC step for the video frame CRC framer.
`default_nettype none
package vfcf_pkg;

    localparam logic [31:0] SESSION_MAGIC  = 32'h4E10_B1BE;
    localparam logic [31:0] FRAME_MAGIC    = 32'hB17E_B1BE;
    localparam logic [31:0] SESSION_WORDS  = 32'd8;
    localparam logic [31:0] SESSION_ONE    = 32'd1;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [31:0] LEN_RESET      = 32'd1658880;
    localparam logic [30:0] VERSION_RESET  = 31'd0;
    localparam int          QUEUE_DEPTH    = 4;

    // configuration register indexes
    localparam logic CFG_PAYLOAD_LENGTH = 1'b0;
    localparam logic CFG_STREAM_VERSION = 1'b1;

    // positions in the byte sequence of one request
    localparam logic [4:0] POS_SESSION = 5'd0;
    localparam logic [4:0] POS_FRAME   = 5'd16;
    localparam logic [4:0] POS_DATA    = 5'd24;
    localparam logic [4:0] POS_CRC_HI  = 5'd25;
    localparam logic [4:0] POS_CRC_LO  = 5'd26;

    // word slots (pos[4:2])
    localparam logic [2:0] W_SESSION_MAGIC = 3'd0;
    localparam logic [2:0] W_SESSION_WORDS = 3'd1;
    localparam logic [2:0] W_VERSION       = 3'd2;
    localparam logic [2:0] W_SESSION_ONE   = 3'd3;
    localparam logic [2:0] W_FRAME_MAGIC   = 3'd4;
    localparam logic [2:0] W_LENGTH        = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart_session;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [30:0] stream_version;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        send_session;
        logic        send_frame;
        logic        frame_end;
        logic [15:0] crc;
    } t_job;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  byte_in);
        logic [15:0] c;
        c = crc_in ^ {byte_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- sv/vfcf_front.sv -----
// Front end: accepts payload bytes, tracks frame position and CRC, classifies each request.
`default_nettype none
module vfcf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire vfcf_pkg::t_in  i_in_data,
    input  wire logic           i_q_ready,
    input  wire vfcf_pkg::t_cfg i_cfg,
    output logic                o_in_ready,
    output logic                o_push,
    output vfcf_pkg::t_job      o_job
);

    logic [31:0] r_count;
    logic [15:0] r_crc;
    logic        r_pending;

    logic        accept;
    logic        frame_start;
    logic        pending_eff;
    logic        frame_end;
    logic [32:0] count_next_wide;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid & i_q_ready;
    assign o_push     = accept;

    assign frame_start     = (r_count == 32'd0);
    assign pending_eff     = r_pending | i_in_data.restart_session;
    assign count_next_wide = {1'b0, r_count} + 33'd1;
    assign frame_end       = (count_next_wide >= {1'b0, i_cfg.payload_length});
    assign crc_base        = frame_start ? vfcf_pkg::CRC_INIT : r_crc;
    assign crc_new         = vfcf_pkg::crc_update(crc_base, i_in_data.data_byte);

    always_comb begin
        o_job.data_byte    = i_in_data.data_byte;
        o_job.send_session = frame_start & pending_eff;
        o_job.send_frame   = frame_start;
        o_job.frame_end    = frame_end;
        o_job.crc          = crc_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 32'd0;
            r_crc     <= vfcf_pkg::CRC_INIT;
            r_pending <= 1'b1;
        end else if (accept) begin
            // a restart seen mid-frame waits for the next frame start
            r_pending <= frame_start ? 1'b0 : pending_eff;
            if (frame_end) begin
                r_count <= 32'd0;
                r_crc   <= vfcf_pkg::CRC_INIT;
            end else begin
                r_count <= count_next_wide[31:0];
                r_crc   <= crc_new;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/vfcf_queue.sv -----
// Short request queue between front and back ends.
`default_nettype none
module vfcf_queue #(
    parameter int DEPTH = vfcf_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vfcf_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_ready,
    output logic                o_valid,
    output vfcf_pkg::t_job      o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vfcf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/vfcf_back.sv -----
// Back end: expands each request into header, payload and CRC bytes, one per cycle unless stalled.
`default_nettype none
module vfcf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire vfcf_pkg::t_job i_head,
    input  wire vfcf_pkg::t_cfg i_cfg,
    input  wire logic           i_out_ready,
    output logic                o_pop,
    output logic                o_out_valid,
    output vfcf_pkg::t_out      o_out_data
);

    logic           r_mid;
    logic [4:0]     r_pos;
    logic           r_out_valid;
    vfcf_pkg::t_out r_out;

    logic           load;
    logic           emit;
    logic [4:0]     start_pos;
    logic [4:0]     end_pos;
    logic [4:0]     pos;
    logic           last;
    logic [31:0]    word;
    logic [7:0]     word_byte;
    vfcf_pkg::t_out n_out;

    assign load = !r_out_valid || i_out_ready;
    assign emit = i_head_valid && load;

    assign start_pos = i_head.send_session ? vfcf_pkg::POS_SESSION :
                       i_head.send_frame   ? vfcf_pkg::POS_FRAME   : vfcf_pkg::POS_DATA;
    assign end_pos   = i_head.frame_end ? vfcf_pkg::POS_CRC_LO : vfcf_pkg::POS_DATA;
    assign pos       = r_mid ? r_pos : start_pos;
    assign last      = (pos == end_pos);
    assign o_pop     = emit && last;

    always_comb begin
        case (pos[4:2])
            vfcf_pkg::W_SESSION_MAGIC: word = vfcf_pkg::SESSION_MAGIC;
            vfcf_pkg::W_SESSION_WORDS: word = vfcf_pkg::SESSION_WORDS;
            vfcf_pkg::W_VERSION:       word = {1'b0, i_cfg.stream_version};
            vfcf_pkg::W_SESSION_ONE:   word = vfcf_pkg::SESSION_ONE;
            vfcf_pkg::W_FRAME_MAGIC:   word = vfcf_pkg::FRAME_MAGIC;
            vfcf_pkg::W_LENGTH:        word = i_cfg.payload_length + 32'd2;
            default:                   word = 32'd0;
        endcase
    end

    // big-endian: slot 0 of a word is its top byte
    always_comb begin
        case (pos[1:0])
            2'd0:    word_byte = word[31:24];
            2'd1:    word_byte = word[23:16];
            2'd2:    word_byte = word[15:8];
            default: word_byte = word[7:0];
        endcase
    end

    always_comb begin
        n_out.frame_end   = 1'b0;
        n_out.last_of_run = last;
        case (pos)
            vfcf_pkg::POS_DATA:   n_out.out_byte = i_head.data_byte;
            vfcf_pkg::POS_CRC_HI: n_out.out_byte = i_head.crc[15:8];
            vfcf_pkg::POS_CRC_LO: begin
                n_out.out_byte  = i_head.crc[7:0];
                n_out.frame_end = 1'b1;
            end
            default:              n_out.out_byte = word_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_pos       <= vfcf_pkg::POS_SESSION;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= i_head_valid;
            end
            if (emit) begin
                r_mid <= !last;
                r_pos <= pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- sv/video_frame_crc_framer_top.sv -----
// Top level of the video frame CRC framer: configuration registers and the front/queue/back chain.
//
//  channel   direction  signals                                  payload
//  in        request    i_in_valid / o_in_ready                   t_in  (data_byte, restart_session)
//  out       result     o_out_valid / i_out_ready                 t_out (out_byte, frame_end, last_of_run)
//  cfg       write      i_cfg_we, i_cfg_index, i_cfg_data         payload_length, stream_version
//
// The back end emits one byte per cycle while the output is not stalled; the number of
// bytes in a request is set by the headers and CRC that it carries; the byte sequencer
// is the limit. The front end accepts one request per cycle while the queue has room,
// so plain payload bytes flow at one per cycle. Reset is synchronous and clears
// control state; no clearing pass follows it. A stall on the output holds the result
// register and backs up into the queue before the input sees it.
`default_nettype none
module video_frame_crc_framer_top #(
    parameter int QUEUE_DEPTH = vfcf_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire vfcf_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output vfcf_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);

    logic [31:0]    r_payload_length;
    logic [30:0]    r_stream_version;
    vfcf_pkg::t_cfg cfg;

    logic           push;
    logic           pop;
    logic           q_ready;
    logic           q_valid;
    vfcf_pkg::t_job front_job;
    vfcf_pkg::t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= vfcf_pkg::LEN_RESET;
            r_stream_version <= vfcf_pkg::VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vfcf_pkg::CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data;
                vfcf_pkg::CFG_STREAM_VERSION: r_stream_version <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign cfg.payload_length = r_payload_length;
    assign cfg.stream_version = r_stream_version;

    vfcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_ready  (q_ready),
        .i_cfg      (cfg),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (front_job)
    );

    vfcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    vfcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_job),
        .i_cfg        (cfg),
        .i_out_ready  (i_out_ready),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule
`default_nettype wire

// ----- sv/vfcf_checker.sv -----
// Port checker for the video frame CRC framer, bound to the top level.
`default_nettype none
`include "video_frame_crc_framer_top_assert.svh"
module vfcf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire vfcf_pkg::t_out o_out_data
);

    `VFCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `VFCF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")
    `VFCF_ASSERT_SAME(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.last_of_run, "frame end not last of run")
    `VFCF_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready, "not empty after reset")

endmodule

bind video_frame_crc_framer_top vfcf_checker u_vfcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
